/* hdl/kufes_pkg.sv */
package kufes_pkg;

  // forest size and derived widths
  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int PTR_W     = $clog2(MAX_NODES + 1);
  localparam int FIELD_W   = 10;
  localparam int CMP_W     = (FIELD_W > PTR_W) ? FIELD_W : PTR_W;
  localparam int RANK_W    = 4;
  localparam int WEIGHT_W  = 32;
  localparam int STATUS_W  = 2;

  localparam logic [PTR_W-1:0]  ROOT_MARK = PTR_W'(MAX_NODES);
  localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(15);
  localparam logic [CMP_W-1:0]  TOP_LIMIT = CMP_W'(MAX_NODES - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_NODES - 1);
  localparam logic [FIELD_W-1:0] NODE_RESET = FIELD_W'(1023);

  // item kinds
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_EDGE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  // one forest entry: parent link and rank
  typedef struct packed {
    logic [PTR_W-1:0]  parent;
    logic [RANK_W-1:0] rank;
  } kufes_entry_t;

  // controller to datapath
  typedef struct packed {
    logic                item_ld;
    logic                walk_start_a;
    logic                walk_step;
    logic                walk_start_b;
    logic                root_b_ld;
    logic                link_b;
    logic                link_a;
    logic                bump_a;
    logic                sweep_start;
    logic                sweep_wr;
    logic                status_ld;
    logic [STATUS_W-1:0] status_val;
    logic                out_ld;
  } kufes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind_edge;
    logic range_bad;
    logic top_zero;
    logic node_root;
    logic roots_same;
    logic rank_gt;
    logic rank_lt;
    logic clear_last;
    logic init_last;
  } kufes_sts_t;

endpackage

/* hdl/kufes_ifs.sv */
// input item channel
interface kufes_in_if
  import kufes_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [FIELD_W-1:0]         node_a;
  logic [FIELD_W-1:0]         node_b;
  logic signed [WEIGHT_W-1:0] weight;

  modport source (output valid, kind, node_a, node_b, weight, input ready);
  modport sink   (input valid, kind, node_a, node_b, weight, output ready);
endinterface

// result item channel
interface kufes_out_if
  import kufes_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [FIELD_W-1:0]         edge_a;
  logic [FIELD_W-1:0]         edge_b;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, status, edge_a, edge_b, edge_weight, input ready);
  modport sink   (input valid, status, edge_a, edge_b, edge_weight, output ready);
endinterface

/* hdl/kufes_datapath.sv */
module kufes_datapath
  import kufes_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [FIELD_W-1:0]         cfg_wdata,
  input  logic                       in_kind,
  input  logic [FIELD_W-1:0]         in_node_a,
  input  logic [FIELD_W-1:0]         in_node_b,
  input  logic signed [WEIGHT_W-1:0] in_weight,
  output logic [STATUS_W-1:0]        out_status,
  output logic [FIELD_W-1:0]         out_edge_a,
  output logic [FIELD_W-1:0]         out_edge_b,
  output logic signed [WEIGHT_W-1:0] out_edge_weight,
  input  kufes_cmd_t                 cmd,
  output kufes_sts_t                 sts
);

  logic [FIELD_W-1:0]         node_count_r;
  logic                       kind_r;
  logic [FIELD_W-1:0]         a_r;
  logic [FIELD_W-1:0]         b_r;
  logic signed [WEIGHT_W-1:0] w_r;
  logic [ADDR_W-1:0]          cur_r;
  logic [ADDR_W-1:0]          cur_nxt;
  logic [ADDR_W-1:0]          root_a_r;
  logic [ADDR_W-1:0]          root_b_r;
  logic [RANK_W-1:0]          rank_a_r;
  logic [RANK_W-1:0]          rank_b_r;
  logic [ADDR_W-1:0]          cnt_r;
  logic [STATUS_W-1:0]        status_r;

  logic [CMP_W-1:0]           a_ext;
  logic [CMP_W-1:0]           b_ext;
  logic [CMP_W-1:0]           cnt_ext;
  logic [CMP_W-1:0]           top_c;
  logic [ADDR_W-1:0]          a_idx;
  logic [ADDR_W-1:0]          b_idx;
  logic [ADDR_W-1:0]          parent_idx;
  logic [RANK_W-1:0]          rank_up;

  kufes_entry_t               mem [MAX_NODES];
  kufes_entry_t               rd_q;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  kufes_entry_t               wr_data;

  // node range and last node in use
  assign a_ext   = CMP_W'(a_r);
  assign b_ext   = CMP_W'(b_r);
  assign cnt_ext = CMP_W'(cnt_r);
  assign top_c   = (CMP_W'(node_count_r) > TOP_LIMIT) ? TOP_LIMIT : CMP_W'(node_count_r);
  assign a_idx      = a_ext[ADDR_W-1:0];
  assign b_idx      = b_ext[ADDR_W-1:0];
  assign parent_idx = rd_q.parent[ADDR_W-1:0];
  assign rank_up    = (rank_a_r == RANK_MAX) ? rank_a_r : rank_a_r + RANK_W'(1);

  // status to controller
  always_comb begin
    sts.kind_edge  = (kind_r == KIND_EDGE);
    sts.range_bad  = (a_ext == '0) || (b_ext == '0) || (a_ext > top_c) || (b_ext > top_c);
    sts.top_zero   = (top_c == '0);
    sts.node_root  = (rd_q.parent >= ROOT_MARK);
    sts.roots_same = (root_a_r == root_b_r);
    sts.rank_gt    = (rank_a_r > rank_b_r);
    sts.rank_lt    = (rank_a_r < rank_b_r);
    sts.clear_last = (cnt_ext == top_c);
    sts.init_last  = (cnt_r == LAST_ADDR);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // sweep counter, zero after reset for the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sweep_start) begin
      cnt_r <= ADDR_W'(1);
    end else if (cmd.sweep_wr) begin
      cnt_r <= cnt_r + ADDR_W'(1);
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      kind_r <= in_kind;
      a_r    <= in_node_a;
      b_r    <= in_node_b;
      w_r    <= in_weight;
    end
  end

  // walk address select
  always_comb begin
    if (cmd.walk_start_a) begin
      rd_addr = a_idx;
    end else if (cmd.walk_start_b) begin
      rd_addr = b_idx;
    end else begin
      rd_addr = parent_idx;
    end
    cur_nxt = rd_addr;
  end

  // walk and root registers
  always_ff @(posedge clk) begin
    if (cmd.walk_start_a || cmd.walk_step || cmd.walk_start_b) begin
      cur_r <= cur_nxt;
    end
    if (cmd.walk_start_b) begin
      root_a_r <= cur_r;
      rank_a_r <= rd_q.rank;
    end
    if (cmd.root_b_ld) begin
      root_b_r <= cur_r;
      rank_b_r <= rd_q.rank;
    end
    if (cmd.status_ld) begin
      status_r <= cmd.status_val;
    end
  end

  // write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cnt_r;
    wr_data = '{parent: ROOT_MARK, rank: '0};
    if (cmd.link_b) begin
      wr_addr = root_b_r;
      wr_data = '{parent: PTR_W'(root_a_r), rank: rank_b_r};
    end else if (cmd.link_a) begin
      wr_addr = root_a_r;
      wr_data = '{parent: PTR_W'(root_b_r), rank: rank_a_r};
    end else if (cmd.bump_a) begin
      wr_addr = root_a_r;
      wr_data = '{parent: ROOT_MARK, rank: rank_up};
    end else if (!cmd.sweep_wr) begin
      wr_en = 1'b0;
    end
  end

  // forest memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status      <= status_r;
      out_edge_a      <= a_r;
      out_edge_b      <= b_r;
      out_edge_weight <= w_r;
    end
  end

endmodule

/* hdl/kufes_ctrl.sv */
module kufes_ctrl
  import kufes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  kufes_sts_t sts,
  output kufes_cmd_t cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_CLEAR  = 4'd3;
  localparam logic [3:0] S_WALK_A = 4'd4;
  localparam logic [3:0] S_WALK_B = 4'd5;
  localparam logic [3:0] S_UNION  = 4'd6;
  localparam logic [3:0] S_BUMP   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.kind_edge) begin
          if (sts.top_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.sweep_start = 1'b1;
            state_nxt       = S_CLEAR;
          end
        end else if (sts.range_bad) begin
          cmd.status_ld  = 1'b1;
          cmd.status_val = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          cmd.walk_start_a = 1'b1;
          state_nxt        = S_WALK_A;
        end
      end
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK_A: begin
        if (sts.node_root) begin
          cmd.walk_start_b = 1'b1;
          state_nxt        = S_WALK_B;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_WALK_B: begin
        if (sts.node_root) begin
          cmd.root_b_ld = 1'b1;
          state_nxt     = S_UNION;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_UNION: begin
        cmd.status_ld = 1'b1;
        state_nxt     = S_DONE;
        if (sts.roots_same) begin
          cmd.status_val = ST_REJECT;
        end else begin
          cmd.status_val = ST_ACCEPT;
          if (sts.rank_lt) begin
            cmd.link_a = 1'b1;
          end else begin
            cmd.link_b = 1'b1;
            if (!sts.rank_gt) begin
              state_nxt = S_BUMP;
            end
          end
        end
      end
      S_BUMP: begin
        cmd.bump_a = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/kruskal_union_find_edge_select_unit.sv */
// edge item: IDLE takes it, then DECODE, walks from node_a and from node_b, UNION (and BUMP
// on an equal-rank join) and DONE, which loads the result register; an out of range edge goes
// from DECODE to DONE; next item in the cycle after the result is stored. clear item: a sweep of
// entries 1 to node_count (at most 1023), one entry per cycle; each link walked is a read on the
// single read port of the forest memory. reset (rst_n low, synchronous) clears control and
// node_count to 1023, then a clearing pass rewrites every entry before the first item is taken
module kruskal_union_find_edge_select_unit
  import kufes_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  kufes_in_if.sink           in_ch,
  kufes_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata
);

  kufes_cmd_t cmd;
  kufes_sts_t sts;

  // sequencing
  kufes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // forest memory and item registers
  kufes_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_node_a       (in_ch.node_a),
    .in_node_b       (in_ch.node_b),
    .in_weight       (in_ch.weight),
    .out_status      (out_ch.status),
    .out_edge_a      (out_ch.edge_a),
    .out_edge_b      (out_ch.edge_b),
    .out_edge_weight (out_ch.edge_weight),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

/* hdl/kufes_checker.sv */
module kufes_checker
  import kufes_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [STATUS_W-1:0]        status,
  input logic [FIELD_W-1:0]         edge_a,
  input logic [FIELD_W-1:0]         edge_b,
  input logic signed [WEIGHT_W-1:0] edge_weight
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(edge_a)
      && $stable(edge_b) && $stable(edge_weight))
    else $error("stalled result changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another in work");

  // node zero is never a valid endpoint
  a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (edge_a == '0 || edge_b == '0) |-> status == ST_RANGE)
    else $error("node zero not flagged");

  // a self loop is never accepted
  a_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && edge_a == edge_b |-> status != ST_ACCEPT)
    else $error("self loop accepted");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind kruskal_union_find_edge_select_unit kufes_checker u_kufes_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .edge_a      (out_ch.edge_a),
  .edge_b      (out_ch.edge_b),
  .edge_weight (out_ch.edge_weight)
);

/* verif/kufes_edge_checker.sv */
`timescale 1ns / 100ps

// watches both channels and the node count register, keeps its own copy of the
// union-find forest and checks every edge decision against it
module kufes_edge_checker
  import kufes_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  kufes_in_if                in_ch,
  kufes_out_if               out_ch,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 results_due,
  output int                 joined_cnt,
  output int                 same_cnt,
  output int                 range_cnt,
  output int                 clear_cnt
);

  // one expected edge decision
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  a;
    logic [FIELD_W-1:0]  b;
    logic [WEIGHT_W-1:0] weight;
  } decision_t;

  // shadow forest and node count
  logic [PTR_W-1:0]   link_mem [MAX_NODES];
  logic [RANK_W-1:0]  rank_mem [MAX_NODES];
  logic [FIELD_W-1:0] node_count;

  decision_t pending_decisions [$];

  // follow parent links until a root, bounded by the forest size
  function automatic logic [ADDR_W-1:0] walk_to_root(input logic [ADDR_W-1:0] n);
    int steps;
    steps = 0;
    while (link_mem[n] < ROOT_MARK && steps < MAX_NODES) begin
      n = link_mem[n][ADDR_W-1:0];
      steps++;
    end
    return n;
  endfunction

  // apply one input item to the shadow forest, queue the decision it causes
  function automatic void predict_decision(input logic kind, input logic [FIELD_W-1:0] a,
                                           input logic [FIELD_W-1:0] b,
                                           input logic [WEIGHT_W-1:0] w);
    logic [CMP_W-1:0]  top;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    decision_t         d;
    top = (CMP_W'(node_count) > TOP_LIMIT) ? TOP_LIMIT : CMP_W'(node_count);
    // clear only touches nodes 1..top
    if (kind == KIND_CLEAR) begin
      for (int i = 1; i <= int'(top); i++) begin
        link_mem[i] = ROOT_MARK;
        rank_mem[i] = '0;
      end
      clear_cnt++;
      return;
    end
    d.a      = a;
    d.b      = b;
    d.weight = w;
    if (a == '0 || b == '0 || CMP_W'(a) > top || CMP_W'(b) > top) begin
      d.status = ST_RANGE;
      range_cnt++;
    end else begin
      ra = walk_to_root(a);
      rb = walk_to_root(b);
      if (ra == rb) begin
        d.status = ST_REJECT;
        same_cnt++;
      end else begin
        d.status = ST_ACCEPT;
        joined_cnt++;
        // union by rank, root of node_a wins a tie
        if (rank_mem[ra] > rank_mem[rb]) begin
          link_mem[rb] = PTR_W'(ra);
        end else if (rank_mem[ra] < rank_mem[rb]) begin
          link_mem[ra] = PTR_W'(rb);
        end else begin
          link_mem[rb] = PTR_W'(ra);
          if (rank_mem[ra] < RANK_MAX) rank_mem[ra] = rank_mem[ra] + 1'b1;
        end
      end
    end
    pending_decisions = {pending_decisions, d};
  endfunction

  always @(posedge clk) begin
    decision_t exp_d;
    if (!rst_n) begin
      node_count = NODE_RESET;
      for (int i = 0; i < MAX_NODES; i++) begin
        link_mem[i] = ROOT_MARK;
        rank_mem[i] = '0;
      end
      pending_decisions.delete();
      fail_count = 0;
      joined_cnt = 0;
      same_cnt   = 0;
      range_cnt  = 0;
      clear_cnt  = 0;
    end else begin
      // result side: compare with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (pending_decisions.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("chk: unexpected result status %0d edge %0d-%0d weight %0d",
                     out_ch.status, out_ch.edge_a, out_ch.edge_b, out_ch.edge_weight);
        end else begin
          exp_d = pending_decisions.pop_front();
          if (out_ch.status !== exp_d.status || out_ch.edge_a !== exp_d.a ||
              out_ch.edge_b !== exp_d.b || out_ch.edge_weight !== exp_d.weight) begin
            fail_count++;
            if (fail_count <= 10)
              $display("chk: expected status %0d edge %0d-%0d weight %0d, got %0d %0d-%0d %0d",
                       exp_d.status, exp_d.a, exp_d.b, $signed(exp_d.weight),
                       out_ch.status, out_ch.edge_a, out_ch.edge_b, out_ch.edge_weight);
          end
        end
      end
      // register write
      if (cfg_we) node_count = cfg_wdata;
      // input side
      if (in_ch.valid && in_ch.ready)
        predict_decision(in_ch.kind, in_ch.node_a, in_ch.node_b, in_ch.weight);
    end
    results_due = pending_decisions.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb
  import kufes_pkg::*;
;

  localparam int STALL_LIMIT   = 8000;
  localparam int SETTLE_CYCLES = 1100;
  localparam int RANDOM_ITEMS  = 650;
  localparam int CALM_ITEMS    = 80;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [FIELD_W-1:0] cfg_wdata;

  kufes_in_if  in_ch ();
  kufes_out_if out_ch ();

  int   fail_count;
  int   results_due;
  int   joined_cnt;
  int   same_cnt;
  int   range_cnt;
  int   clear_cnt;
  int   items_sent   = 0;
  int   count_writes = 0;
  int   idle_pct     = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;

  kruskal_union_find_edge_select_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kufes_edge_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_due (results_due),
    .joined_cnt  (joined_cnt),
    .same_cnt    (same_cnt),
    .range_cnt   (range_cnt),
    .clear_cnt   (clear_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side stalls in random bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end else if (!calm && $urandom_range(99) < idle_pct) begin
      hold_left = $urandom_range(1, 11);
    end
    out_ch.ready <= (hold_left == 0);
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // offer one item, maybe after a gap, and wait until it is taken
  task automatic send_item(input logic kind, input logic [FIELD_W-1:0] a,
                           input logic [FIELD_W-1:0] b, input logic [WEIGHT_W-1:0] w);
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    in_ch.weight <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // drain, let a pending clear sweep finish, then write the node count
  task automatic write_node_count(input int n);
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= FIELD_W'(n);
    @(negedge clk);
    cfg_we <= 1'b0;
    count_writes++;
  endtask

  initial begin
    int                  nc;
    int                  pick;
    int                  target;
    logic [FIELD_W-1:0]  a;
    logic [WEIGHT_W-1:0] w;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_CLEAR;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    in_ch.weight = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every join rule and the out of range cases at reset count
    send_item(KIND_EDGE, 10'd1, 10'd1023, 32'h7FFF_FFFF);
    send_item(KIND_EDGE, 10'd1023, 10'd1, 32'h8000_0000);
    send_item(KIND_EDGE, 10'd5, 10'd5, 32'h0000_0000);
    send_item(KIND_EDGE, 10'd0, 10'd3, 32'hFFFF_FFFF);
    send_item(KIND_EDGE, 10'd3, 10'd0, 32'h0000_0001);
    send_item(KIND_EDGE, 10'd2, 10'd3, 32'h5555_5555);
    send_item(KIND_EDGE, 10'd1, 10'd2, 32'hAAAA_AAAA);
    send_item(KIND_EDGE, 10'd4, 10'd1, 32'h0000_0100);
    send_item(KIND_EDGE, 10'd1, 10'd6, 32'h0000_00FF);
    send_item(KIND_EDGE, 10'd3, 10'd1023, 32'h0000_0010);
    send_item(KIND_CLEAR, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
    send_item(KIND_EDGE, 10'd1, 10'd1023, 32'h0000_0008);
    send_item(KIND_EDGE, 10'h2AA, 10'h155, 32'h0000_0004);

    // zero node count: every edge out of range, clear does nothing
    write_node_count(0);
    send_item(KIND_EDGE, 10'd1, 10'd2, 32'h0000_0003);
    send_item(KIND_CLEAR, 10'd0, 10'd0, 32'h0000_0000);
    send_item(KIND_EDGE, 10'd1023, 10'd1023, 32'h0000_0002);

    // single node: self loop in range, clear reaches node 1 only
    write_node_count(1);
    send_item(KIND_EDGE, 10'd1, 10'd1, 32'h0000_0001);
    send_item(KIND_EDGE, 10'd1, 10'd2, 32'h0000_0000);
    send_item(KIND_CLEAR, 10'd0, 10'd0, 32'h0000_0000);

    // full count again without clearing: links above the last clear survive
    write_node_count(1023);
    send_item(KIND_EDGE, 10'd1023, 10'd1, 32'hFFFF_FFF0);
    send_item(KIND_EDGE, 10'h155, 10'h2AA, 32'hFFFF_FF00);
    send_item(KIND_EDGE, 10'd2, 10'd4, 32'h8000_0001);

    // random groups: mostly a clear then a sorted edge list with random endpoints
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 3) nc = 0;
      else if (pick < 8) nc = 1;
      else if (pick < 18) nc = 1023;
      else if (pick < 30) nc = $urandom_range(65, 1022);
      else nc = $urandom_range(2, 64);
      write_node_count(nc);
      pick = $urandom_range(2);
      idle_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
      if ($urandom_range(99) < 85)
        send_item(KIND_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
      w = $urandom;
      repeat ($urandom_range(8, 40)) begin
        calm = (items_sent >= target - CALM_ITEMS);
        pick = $urandom_range(99);
        w = w - $urandom_range(0, 5000);
        if (pick < 80 && nc > 0) begin
          send_item(KIND_EDGE, FIELD_W'($urandom_range(1, nc)),
                    FIELD_W'($urandom_range(1, nc)), w);
        end else if (pick < 88) begin
          send_item(KIND_EDGE, FIELD_W'($urandom_range(0, 1023)),
                    FIELD_W'($urandom_range(0, 1023)), $urandom);
        end else if (pick < 95) begin
          a = (nc > 0) ? FIELD_W'($urandom_range(1, nc)) : FIELD_W'($urandom_range(0, 1023));
          send_item(KIND_EDGE, a, a, w);
        end else begin
          send_item(KIND_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
        end
      end
    end

    // drain and let the last clear sweep settle
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("tb: %0d items over %0d node count settings, %0d of them clears",
             items_sent, count_writes, clear_cnt);
    $display("tb: edges joined %0d, same component %0d, out of range %0d",
             joined_cnt, same_cnt, range_cnt);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
